[sv/u2u_pkg.sv]
// ----------------------------------------------------------------------------
// u2u_pkg
// Shared types and constants of the UTF-8 to UTF-16 decoder.
// ----------------------------------------------------------------------------
package u2u_pkg;

  // Result kinds
  typedef enum logic [1:0] {
    KIND_UNIT = 2'd0,
    KIND_OK   = 2'd1,
    KIND_FAIL = 2'd2
  } kind_t;

  // Event passed from the front to the back: a code point or an end mark
  typedef struct packed {
    kind_t       kind;
    logic [20:0] cp;
  } evt_t;

  localparam logic [20:0] CP_MAX    = 21'h10FFFF;
  localparam logic [20:0] SURR_LO   = 21'h00D800;
  localparam logic [20:0] SURR_HI   = 21'h00DFFF;
  localparam logic [20:0] PLANE1    = 21'h010000;
  localparam logic [20:0] MIN_THREE = 21'h000800;
  localparam logic [20:0] MIN_TWO   = 21'h000080;
  localparam logic [15:0] HIGH_SURR = 16'hD800;
  localparam logic [15:0] LOW_SURR  = 16'hDC00;

  // Event queue geometry
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

endpackage

[sv/u2u_front.sv]
// ----------------------------------------------------------------------------
// u2u_front
// Byte classifier: gathers UTF-8 sequences, checks them, and issues one event
// per completed code point or terminator.
// ----------------------------------------------------------------------------
module u2u_front (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           byte_accept,
  input  logic [7:0]     text_byte,
  output logic           evt_valid,
  output u2u_pkg::evt_t  evt
);
  import u2u_pkg::*;

  logic [1:0]  pending_r, pending_nxt;
  logic [1:0]  seq_len_r, seq_len_nxt;
  logic [20:0] partial_r, partial_nxt;
  logic        failed_r, failed_nxt;

  logic [20:0] cp_cont;
  logic        bad;

  // Code point after shifting in one continuation beat
  assign cp_cont = {partial_r[14:0], text_byte[5:0]};

  // Overlong, out of range or surrogate value
  always_comb begin
    bad = (cp_cont > CP_MAX) || ((cp_cont >= SURR_LO) && (cp_cont <= SURR_HI));
    unique case (seq_len_r)
      2'd1:    if (cp_cont < MIN_TWO) bad = 1'b1;
      2'd2:    if (cp_cont < MIN_THREE) bad = 1'b1;
      2'd3:    if (cp_cont < PLANE1) bad = 1'b1;
      default: ;
    endcase
  end

  // Classify one beat
  always_comb begin
    pending_nxt = pending_r;
    seq_len_nxt = seq_len_r;
    partial_nxt = partial_r;
    failed_nxt  = failed_r;
    evt_valid   = 1'b0;
    evt.kind    = KIND_UNIT;
    evt.cp      = '0;
    if (byte_accept) begin
      priority if (text_byte == 8'd0) begin
        evt_valid   = 1'b1;
        evt.kind    = (failed_r || pending_r != 2'd0) ? KIND_FAIL : KIND_OK;
        pending_nxt = '0;
        seq_len_nxt = '0;
        partial_nxt = '0;
        failed_nxt  = 1'b0;
      end else if (failed_r) begin
        // drop bytes until the terminator
      end else if (pending_r == 2'd0) begin
        priority if (!text_byte[7]) begin
          evt_valid = 1'b1;
          evt.cp    = {13'd0, text_byte};
        end else if (text_byte[7:5] == 3'b110) begin
          partial_nxt = {16'd0, text_byte[4:0]};
          seq_len_nxt = 2'd1;
          pending_nxt = 2'd1;
        end else if (text_byte[7:4] == 4'b1110) begin
          partial_nxt = {17'd0, text_byte[3:0]};
          seq_len_nxt = 2'd2;
          pending_nxt = 2'd2;
        end else if (text_byte[7:3] == 5'b11110) begin
          partial_nxt = {18'd0, text_byte[2:0]};
          seq_len_nxt = 2'd3;
          pending_nxt = 2'd3;
        end else begin
          failed_nxt = 1'b1;
        end
      end else if (text_byte[7:6] != 2'b10) begin
        failed_nxt  = 1'b1;
        pending_nxt = '0;
        seq_len_nxt = '0;
        partial_nxt = '0;
      end else if (pending_r != 2'd1) begin
        partial_nxt = cp_cont;
        pending_nxt = pending_r - 2'd1;
      end else begin
        pending_nxt = '0;
        seq_len_nxt = '0;
        partial_nxt = '0;
        if (bad) begin
          failed_nxt = 1'b1;
        end else begin
          evt_valid = 1'b1;
          evt.cp    = cp_cont;
        end
      end
    end
  end

  // Hold sequence state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r <= '0;
      seq_len_r <= '0;
      partial_r <= '0;
      failed_r  <= 1'b0;
    end else begin
      pending_r <= pending_nxt;
      seq_len_r <= seq_len_nxt;
      partial_r <= partial_nxt;
      failed_r  <= failed_nxt;
    end
  end

endmodule

[sv/u2u_queue.sv]
// ----------------------------------------------------------------------------
// u2u_queue
// Short event queue between the classifier and the unit emitter.
// ----------------------------------------------------------------------------
module u2u_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  u2u_pkg::evt_t  push_evt,
  output logic           full,
  input  logic           pop,
  output u2u_pkg::evt_t  head_evt,
  output logic           empty
);
  import u2u_pkg::*;

  evt_t                mem [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QUEUE_AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QUEUE_CW-1:0] count_r, count_nxt;
  logic                do_push, do_pop;

  assign full     = (count_r == QUEUE_CW'(QUEUE_DEPTH));
  assign empty    = (count_r == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign head_evt = mem[rd_ptr_r];

  // Advance pointers and count
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) wr_ptr_nxt = (wr_ptr_r == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    if (do_pop)  rd_ptr_nxt = (rd_ptr_r == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    if (do_push && !do_pop) count_nxt = count_r + 1'b1;
    if (do_pop && !do_push) count_nxt = count_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Store entries
  always_ff @(posedge clk) begin
    if (do_push) mem[wr_ptr_r] <= push_evt;
  end

endmodule

[sv/u2u_back.sv]
// ----------------------------------------------------------------------------
// u2u_back
// Unit emitter: turns events into UTF-16 units or end items, splitting
// supplementary code points into surrogate pairs, behind an output register.
// ----------------------------------------------------------------------------
module u2u_back (
  input  logic           clk,
  input  logic           rst_n,
  input  u2u_pkg::evt_t  head_evt,
  input  logic           q_empty,
  output logic           q_pop,
  output logic [15:0]    code_unit,
  output logic [1:0]     kind,
  output logic           last_of_step,
  output logic           empty,
  input  logic           pop
);
  import u2u_pkg::*;

  logic        out_valid_r, out_valid_nxt;
  logic [15:0] unit_r, unit_nxt;
  kind_t       kind_r, kind_nxt;
  logic        last_r, last_nxt;
  logic        low_pend_r, low_pend_nxt;
  logic [15:0] low_unit_r, low_unit_nxt;

  logic        load_ok;
  logic [20:0] offset;

  assign load_ok = !out_valid_r || pop;
  assign offset  = head_evt.cp - PLANE1;

  // Fill the output register: pending low half first, then a new event
  always_comb begin
    out_valid_nxt = out_valid_r;
    unit_nxt      = unit_r;
    kind_nxt      = kind_r;
    last_nxt      = last_r;
    low_pend_nxt  = low_pend_r;
    low_unit_nxt  = low_unit_r;
    q_pop         = 1'b0;
    if (load_ok) begin
      priority if (low_pend_r) begin
        out_valid_nxt = 1'b1;
        unit_nxt      = low_unit_r;
        kind_nxt      = KIND_UNIT;
        last_nxt      = 1'b1;
        low_pend_nxt  = 1'b0;
      end else if (!q_empty) begin
        q_pop         = 1'b1;
        out_valid_nxt = 1'b1;
        kind_nxt      = head_evt.kind;
        last_nxt      = 1'b1;
        if (head_evt.kind != KIND_UNIT) begin
          unit_nxt = '0;
        end else if (head_evt.cp[20:16] != 5'd0) begin
          unit_nxt     = HIGH_SURR | {6'd0, offset[19:10]};
          last_nxt     = 1'b0;
          low_pend_nxt = 1'b1;
          low_unit_nxt = LOW_SURR | {6'd0, offset[9:0]};
        end else begin
          unit_nxt = head_evt.cp[15:0];
        end
      end else begin
        out_valid_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      low_pend_r  <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      low_pend_r  <= low_pend_nxt;
    end
  end

  // Payload holds
  always_ff @(posedge clk) begin
    unit_r     <= unit_nxt;
    kind_r     <= kind_nxt;
    last_r     <= last_nxt;
    low_unit_r <= low_unit_nxt;
  end

  assign empty        = !out_valid_r;
  assign code_unit    = unit_r;
  assign kind         = kind_r;
  assign last_of_step = last_r;

endmodule

[sv/utf8_to_utf16_decoder.sv]
// ----------------------------------------------------------------------------
// utf8_to_utf16_decoder
// Streaming UTF-8 to UTF-16 decoder for zero-terminated strings.
// ----------------------------------------------------------------------------
// Channel   Ports                                     Beat moves when
// input     push, full, in_text_byte                  push && !full
// result    empty, pop, out_code_unit, out_kind,      pop && !empty
//           out_last_of_step
//
// One byte is taken every cycle while the event queue has room; a byte's
// results pass through the event queue and then the output register.
// A supplementary code point leaves as two beats; the four-entry event queue
// absorbs that extra beat so input keeps flowing.
// Synchronous active-low reset clears sequence state, queue and output.
// Output stalls back up through the queue and raise full only when it fills.
// ----------------------------------------------------------------------------
module utf8_to_utf16_decoder (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  in_text_byte,
  output logic        empty,
  input  logic        pop,
  output logic [15:0] out_code_unit,
  output logic [1:0]  out_kind,
  output logic        out_last_of_step
);
  import u2u_pkg::*;

  logic byte_accept;
  logic evt_valid;
  evt_t evt;
  evt_t head_evt;
  logic q_empty;
  logic q_pop;

  assign byte_accept = push && !full;

  // Classify bytes
  u2u_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .byte_accept (byte_accept),
    .text_byte   (in_text_byte),
    .evt_valid   (evt_valid),
    .evt         (evt)
  );

  // Decouple classifier from emitter
  u2u_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (evt_valid),
    .push_evt (evt),
    .full     (full),
    .pop      (q_pop),
    .head_evt (head_evt),
    .empty    (q_empty)
  );

  // Emit units
  u2u_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .head_evt     (head_evt),
    .q_empty      (q_empty),
    .q_pop        (q_pop),
    .code_unit    (out_code_unit),
    .kind         (out_kind),
    .last_of_step (out_last_of_step),
    .empty        (empty),
    .pop          (pop)
  );

endmodule

[tb/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Checks the UTF-8 to UTF-16 decoder against a cycle-free decoder model kept
// in the bench. Directed strings cover the encoding bounds and every reject
// rule. Random strings follow, mostly well formed with some defects and noise.
// Both handshakes idle in random bursts, and one phase holds the result side
// off so that the input stalls.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import u2u_pkg::*;

  // One UTF-16 beat as the result port shows it
  typedef struct {
    logic [15:0] unit;
    kind_t       kind;
    logic        last;
  } utf16_beat_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        push;
  logic        full;
  logic [7:0]  in_text_byte;
  logic        empty;
  logic        pop;
  logic [15:0] out_code_unit;
  logic [1:0]  out_kind;
  logic        out_last_of_step;

  // Expected beats, oldest first
  utf16_beat_t utf16_expected[$];
  // Bytes of the string being built, terminator not included
  logic [7:0]  text_bytes[$];

  // Decoder model state
  logic [1:0]  dec_pending;
  logic [1:0]  dec_len;
  logic [20:0] dec_cp;
  logic        dec_failed;

  int error_count = 0;
  int byte_count  = 0;
  int rx_hold_req = 0;
  bit tx_idle_on  = 1'b1;
  bit rx_idle_on  = 1'b1;
  bit tail_mode   = 1'b0;

  utf8_to_utf16_decoder uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .push             (push),
    .full             (full),
    .in_text_byte     (in_text_byte),
    .empty            (empty),
    .pop              (pop),
    .out_code_unit    (out_code_unit),
    .out_kind         (out_kind),
    .out_last_of_step (out_last_of_step)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Decoder model
  // --------------------------------------------------------------------------
  function automatic void expect_beat(input logic [15:0] unit, input kind_t kind,
                                      input logic last);
    utf16_beat_t b;
    b.unit = unit;
    b.kind = kind;
    b.last = last;
    utf16_expected.push_back(b);
  endfunction

  function automatic void fail_text();
    dec_failed  = 1'b1;
    dec_pending = 2'd0;
    dec_len     = 2'd0;
    dec_cp      = 21'd0;
  endfunction

  function automatic void decode_byte(input logic [7:0] value);
    logic [20:0] cp;
    logic [20:0] offset;
    logic        bad;
    // Terminator closes the string and clears everything
    if (value == 8'h00) begin
      expect_beat(16'h0000, (dec_failed || dec_pending != 2'd0) ? KIND_FAIL : KIND_OK,
                  1'b1);
      dec_pending = 2'd0;
      dec_len     = 2'd0;
      dec_cp      = 21'd0;
      dec_failed  = 1'b0;
      return;
    end
    if (dec_failed) return;
    // Lead byte
    if (dec_pending == 2'd0) begin
      if (value[7] == 1'b0) begin
        expect_beat({8'h00, value}, KIND_UNIT, 1'b1);
        return;
      end
      if (value[7:5] == 3'b110) begin
        dec_cp  = {16'd0, value[4:0]};
        dec_len = 2'd1;
      end else if (value[7:4] == 4'b1110) begin
        dec_cp  = {17'd0, value[3:0]};
        dec_len = 2'd2;
      end else if (value[7:3] == 5'b11110) begin
        dec_cp  = {18'd0, value[2:0]};
        dec_len = 2'd3;
      end else begin
        fail_text();
        return;
      end
      dec_pending = dec_len;
      return;
    end
    // Continuation byte
    if (value[7:6] != 2'b10) begin
      fail_text();
      return;
    end
    dec_cp      = {dec_cp[14:0], value[5:0]};
    dec_pending = dec_pending - 2'd1;
    if (dec_pending != 2'd0) return;
    cp  = dec_cp;
    bad = (dec_len == 2'd1 && cp < MIN_TWO) || (dec_len == 2'd2 && cp < MIN_THREE) ||
          (dec_len == 2'd3 && cp < PLANE1) || cp > CP_MAX ||
          (cp >= SURR_LO && cp <= SURR_HI);
    dec_len = 2'd0;
    dec_cp  = 21'd0;
    if (bad) begin
      fail_text();
      return;
    end
    if (cp <= 21'h00FFFF) begin
      expect_beat(cp[15:0], KIND_UNIT, 1'b1);
    end else begin
      offset = cp - PLANE1;
      expect_beat(HIGH_SURR | {6'd0, offset[19:10]}, KIND_UNIT, 1'b0);
      expect_beat(LOW_SURR | {6'd0, offset[9:0]}, KIND_UNIT, 1'b1);
    end
  endfunction

  // --------------------------------------------------------------------------
  // String building
  // --------------------------------------------------------------------------
  function automatic int utf8_length(input logic [20:0] cp);
    if (cp < 21'h80) return 1;
    if (cp < 21'h800) return 2;
    if (cp < 21'h10000) return 3;
    return 4;
  endfunction

  // Append cp in an n-byte form; a longer form than needed gives an overlong,
  // and n of zero picks the shortest form
  function automatic void append_utf8(input logic [20:0] cp, input int n);
    int len;
    len = (n == 0) ? utf8_length(cp) : n;
    case (len)
      1: text_bytes.push_back({1'b0, cp[6:0]});
      2: begin
        text_bytes.push_back({3'b110, cp[10:6]});
        text_bytes.push_back({2'b10, cp[5:0]});
      end
      3: begin
        text_bytes.push_back({4'b1110, cp[15:12]});
        text_bytes.push_back({2'b10, cp[11:6]});
        text_bytes.push_back({2'b10, cp[5:0]});
      end
      default: begin
        text_bytes.push_back({5'b11110, cp[20:18]});
        text_bytes.push_back({2'b10, cp[17:12]});
        text_bytes.push_back({2'b10, cp[11:6]});
        text_bytes.push_back({2'b10, cp[5:0]});
      end
    endcase
  endfunction

  function automatic logic [20:0] pick_valid_point();
    logic [20:0] cp;
    case ($urandom_range(0, 4))
      0: cp = 21'($urandom_range(1, 'h7F));
      1: cp = 21'($urandom_range('h80, 'h7FF));
      2: begin
        cp = 21'($urandom_range('h800, 'hFFFF));
        // move surrogates up into the range F800..FFFF
        if (cp >= SURR_LO && cp <= SURR_HI) cp = cp ^ 21'h002000;
      end
      3: cp = 21'($urandom_range('h10000, 'h10FFFF));
      default: begin
        case ($urandom_range(0, 8))
          0: cp = 21'h7F;
          1: cp = 21'h80;
          2: cp = 21'h7FF;
          3: cp = 21'h800;
          4: cp = 21'hD7FF;
          5: cp = 21'hE000;
          6: cp = 21'hFFFF;
          7: cp = 21'h10000;
          default: cp = 21'h10FFFF;
        endcase
      end
    endcase
    return cp;
  endfunction

  function automatic void append_defect();
    logic [20:0] cp;
    int          n;
    int          cut;
    case ($urandom_range(0, 5))
      0: text_bytes.push_back(8'($urandom_range(1, 255)));
      1: begin
        // overlong: a value that fits in fewer bytes
        n = $urandom_range(2, 4);
        if (n == 2) cp = 21'($urandom_range(0, 'h7F));
        else if (n == 3) cp = 21'($urandom_range(0, 'h7FF));
        else cp = 21'($urandom_range(0, 'hFFFF));
        append_utf8(cp, n);
      end
      2: append_utf8(21'($urandom_range('hD800, 'hDFFF)), 3);
      3: append_utf8(21'($urandom_range('h110000, 'h1FFFFF)), 4);
      4: begin
        if ($urandom_range(0, 1) == 0) text_bytes.push_back(8'($urandom_range('hF8, 'hFF)));
        else text_bytes.push_back(8'($urandom_range('h80, 'hBF)));
      end
      default: begin
        // truncated sequence: drop trailing continuations
        cp = 21'($urandom_range('h80, 'h10FFFF));
        if (cp >= SURR_LO && cp <= SURR_HI) cp = cp ^ 21'h002000;
        n = utf8_length(cp);
        append_utf8(cp, n);
        cut = $urandom_range(1, n - 1);
        repeat (cut) void'(text_bytes.pop_back());
      end
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Input side
  // --------------------------------------------------------------------------
  task automatic send_byte(input logic [7:0] value);
    int gap;
    gap = 0;
    if (tx_idle_on && !tail_mode && $urandom_range(0, 7) == 0) gap = $urandom_range(1, 10);
    if (gap != 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push         <= 1'b1;
    in_text_byte <= value;
    do @(posedge clk); while (full);
    decode_byte(value);
    byte_count++;
  endtask

  // Send the built string followed by its terminator
  task automatic send_text();
    foreach (text_bytes[i]) send_byte(text_bytes[i]);
    send_byte(8'h00);
  endtask

  task automatic send_random_string();
    int points;
    tx_idle_on = ($urandom_range(0, 3) != 0);
    text_bytes.delete();
    points = $urandom_range(0, 10);
    if ($urandom_range(0, 9) == 0) begin
      // noise: any nonzero bytes
      repeat (points) text_bytes.push_back(8'($urandom_range(1, 255)));
    end else begin
      repeat (points) begin
        if ($urandom_range(0, 14) == 0) append_defect();
        else append_utf8(pick_valid_point(), 0);
      end
    end
    send_text();
  endtask

  // Stop offering bytes until every expected beat has come back
  task automatic drain_results();
    push <= 1'b0;
    while (utf16_expected.size() != 0) @(posedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Result side: pop with random bursts of idle, check each beat
  // --------------------------------------------------------------------------
  task automatic check_beat();
    utf16_beat_t want;
    if (utf16_expected.size() == 0) begin
      $error("unexpected beat: code_unit %h kind %0d last_of_step %0b",
             out_code_unit, out_kind, out_last_of_step);
      error_count++;
      return;
    end
    want = utf16_expected.pop_front();
    if (out_code_unit !== want.unit) begin
      $error("code_unit: expected %h, actual %h", want.unit, out_code_unit);
      error_count++;
    end
    if (out_kind !== want.kind) begin
      $error("kind: expected %0d, actual %0d", want.kind, out_kind);
      error_count++;
    end
    if (out_last_of_step !== want.last) begin
      $error("last_of_step: expected %0b, actual %0b", want.last, out_last_of_step);
      error_count++;
    end
  endtask

  initial begin
    int gap_left;
    int hold_left;
    gap_left  = 0;
    hold_left = 0;
    pop <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && pop && !empty) check_beat();
      if (rx_hold_req != 0) begin
        hold_left   = rx_hold_req;
        rx_hold_req = 0;
      end
      if (!tail_mode && $urandom_range(0, 63) == 0) rx_idle_on = !rx_idle_on;
      // hold, then idle bursts, else pop
      if (!rst_n) begin
        pop <= 1'b0;
      end else if (hold_left != 0) begin
        hold_left--;
        pop <= 1'b0;
      end else if (gap_left != 0) begin
        gap_left--;
        pop <= 1'b0;
      end else if (rx_idle_on && !tail_mode && $urandom_range(0, 5) == 0) begin
        gap_left = $urandom_range(0, 9);
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  // Top of every encoding length and bottom of the three- and four-byte forms, then an empty string
  task automatic test_valid_forms();
    text_bytes = '{8'h7F, 8'hDF, 8'hBF, 8'hE0, 8'hA0, 8'h80, 8'hEF, 8'hBF, 8'hBF,
                   8'hF0, 8'h90, 8'h80, 8'h80, 8'hF4, 8'h8F, 8'hBF, 8'hBF};
    send_text();
    text_bytes.delete();
    send_text();
  endtask

  // One string per reject rule
  task automatic test_rejects();
    // encoded surrogate, then a byte that must be ignored
    text_bytes = '{8'hED, 8'hA0, 8'h80, 8'h41};
    send_text();
    // above the last code point
    text_bytes = '{8'hF4, 8'h90, 8'h80, 8'h80};
    send_text();
    // overlong two-byte form
    text_bytes = '{8'hC1, 8'hBF};
    send_text();
    // bad lead byte
    text_bytes = '{8'hFF};
    send_text();
    // missing continuation
    text_bytes = '{8'hC3, 8'h41};
    send_text();
    // cut off by the terminator
    text_bytes = '{8'hE2, 8'h82};
    send_text();
  endtask

  task automatic test_random_strings();
    int target;
    target = byte_count + 200;
    while (byte_count < target) send_random_string();
  endtask

  // Hold the result side off so the queue fills and full rises
  task automatic test_backpressure();
    drain_results();
    tx_idle_on  = 1'b0;
    rx_hold_req = 120;
    text_bytes.delete();
    repeat (12) append_utf8(pick_valid_point(), 0);
    foreach (text_bytes[i]) send_byte(text_bytes[i]);
    send_byte(8'h00);
    drain_results();
  endtask

  // No idling on either side
  task automatic test_full_rate_tail();
    int target;
    tail_mode  = 1'b1;
    rx_idle_on = 1'b0;
    target = byte_count + 60;
    while (byte_count < target) send_random_string();
  endtask

  initial begin
    rst_n        <= 1'b0;
    push         <= 1'b0;
    in_text_byte <= 8'h00;
    dec_pending  = 2'd0;
    dec_len      = 2'd0;
    dec_cp       = 21'd0;
    dec_failed   = 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_valid_forms();
    test_rejects();
    test_random_strings();
    test_backpressure();
    test_random_strings();
    test_full_rate_tail();

    drain_results();
    repeat (16) @(posedge clk);
    if (error_count == 0 && utf16_expected.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Run limit
  initial begin
    #2000000;
    $display("Verification failed");
    $finish;
  end

endmodule
